FILE: sv/lsystem_symbol_rewriter_defines.svh
// assertion macros for the symbol rewriter
// used by the top level only; expects clk_i and rst_ni in scope
`ifndef LSYSTEM_SYMBOL_REWRITER_DEFINES_SVH
`define LSYSTEM_SYMBOL_REWRITER_DEFINES_SVH

// same-cycle implication, off during reset
`define LSR_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("lsr: assertion failed");

// next-cycle implication, off during reset
`define LSR_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("lsr: assertion failed");

`endif

FILE: sv/lsr_pkg.sv
// shared types and constants of the symbol rewriter
// no dependencies
`timescale 1ns / 1ps

package lsr_pkg;

  // port field widths
  localparam int REQ_W      = 2;
  localparam int SYM_PORT_W = 8;
  localparam int IDX_PORT_W = 4;
  localparam int POS_PORT_W = 6;
  localparam int LEN_PORT_W = 7;

  // request codes
  localparam logic [REQ_W-1:0] REQ_REWRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_HEADER  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SUCC    = 2'd2;

  // queue sizing; entry fields hold the widest parameter range
  localparam int QUEUE_DEPTH = 4;
  localparam int Q_ADDR_W    = 16;
  localparam int Q_LEN_W     = 8;

  // work kinds handed from front to back
  typedef enum logic [1:0] {
    K_PASS,
    K_HIT,
    K_WRITE
  } kind_e;

  typedef struct packed {
    kind_e                 kind;
    logic [SYM_PORT_W-1:0] sym;
    logic [Q_ADDR_W-1:0]   addr;
    logic [Q_LEN_W-1:0]    len;
  } qent_t;

  // back-end sequencer states
  typedef enum logic {
    BK_IDLE,
    BK_DATA
  } bk_state_e;

endpackage

FILE: sv/lsr_front.sv
// front end: accepts beats, holds the rule table, classifies rewrites
// depends on lsr_pkg
`timescale 1ns / 1ps

module lsr_front #(
  parameter int NUM_RULES    = 16,
  parameter int MAX_SUCC_LEN = 64,
  parameter int SYMBOL_BITS  = 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [lsr_pkg::REQ_W-1:0]         req_type_i,
  input  logic [lsr_pkg::SYM_PORT_W-1:0]    symbol_i,
  input  logic [lsr_pkg::IDX_PORT_W-1:0]    rule_index_i,
  input  logic [lsr_pkg::POS_PORT_W-1:0]    position_i,
  input  logic [lsr_pkg::LEN_PORT_W-1:0]    succ_length_i,
  input  logic                              rule_enable_i,
  input  logic                              q_full_i,
  output logic                              q_push_o,
  output lsr_pkg::qent_t                    q_entry_o
);

  localparam int SymW = (SYMBOL_BITS < lsr_pkg::SYM_PORT_W) ? SYMBOL_BITS
                                                            : lsr_pkg::SYM_PORT_W;
  localparam int IdxW = (NUM_RULES > 1) ? $clog2(NUM_RULES) : 1;
  localparam int LenW = $clog2(MAX_SUCC_LEN + 1);

  logic [NUM_RULES-1:0] valid_q;
  logic [SymW-1:0]      pred_q [NUM_RULES];
  logic [LenW-1:0]      len_q  [NUM_RULES];

  logic            accept;
  logic [SymW-1:0] sym_m;
  logic [IdxW-1:0] idx;
  logic            idx_ok;
  logic            pos_ok;
  logic [8:0]      len_ext;
  logic [LenW-1:0] len_sat;
  logic            hit_any;
  logic [IdxW-1:0] win;

  assign accept     = in_valid_i && !q_full_i;
  assign in_stall_o = q_full_i;

  // field conditioning
  assign sym_m   = symbol_i[SymW-1:0];
  assign idx     = IdxW'(rule_index_i);
  assign idx_ok  = {5'd0, rule_index_i} < 9'(NUM_RULES);
  assign pos_ok  = {3'd0, position_i} < 9'(MAX_SUCC_LEN);
  assign len_ext = {2'd0, succ_length_i};

  // saturate the successor length
  always_comb begin
    if (len_ext > 9'(MAX_SUCC_LEN)) begin
      len_sat = LenW'(MAX_SUCC_LEN);
    end else begin
      len_sat = LenW'(len_ext);
    end
  end

  // lowest matching valid rule
  always_comb begin
    hit_any = 1'b0;
    win     = '0;
    for (int r = NUM_RULES - 1; r >= 0; r--) begin
      if (valid_q[r] && (pred_q[r] == sym_m)) begin
        hit_any = 1'b1;
        win     = IdxW'(r);
      end
    end
  end

  // rule valid marks
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (accept && (req_type_i == lsr_pkg::REQ_HEADER) && idx_ok) begin
      valid_q[idx] <= rule_enable_i;
    end
  end

  // rule predecessor and length
  always_ff @(posedge clk_i) begin
    if (accept && (req_type_i == lsr_pkg::REQ_HEADER) && idx_ok) begin
      pred_q[idx] <= sym_m;
      len_q[idx]  <= len_sat;
    end
  end

  // queue entry build
  always_comb begin
    q_push_o       = 1'b0;
    q_entry_o.kind = lsr_pkg::K_PASS;
    q_entry_o.sym  = lsr_pkg::SYM_PORT_W'(sym_m);
    q_entry_o.addr = '0;
    q_entry_o.len  = '0;
    case (req_type_i)
      lsr_pkg::REQ_REWRITE: begin
        q_push_o = accept;
        if (hit_any) begin
          q_entry_o.kind = lsr_pkg::K_HIT;
          q_entry_o.addr = lsr_pkg::Q_ADDR_W'(win * MAX_SUCC_LEN);
          q_entry_o.len  = lsr_pkg::Q_LEN_W'(len_q[win]);
        end
      end
      lsr_pkg::REQ_SUCC: begin
        q_push_o       = accept && idx_ok && pos_ok;
        q_entry_o.kind = lsr_pkg::K_WRITE;
        q_entry_o.addr = lsr_pkg::Q_ADDR_W'(idx * MAX_SUCC_LEN + position_i);
      end
      default: begin
        q_push_o = 1'b0;
      end
    endcase
  end

endmodule

FILE: sv/lsr_queue.sv
// short queue between front and back end
// depends on lsr_pkg
`timescale 1ns / 1ps

module lsr_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  lsr_pkg::qent_t entry_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           empty_o,
  output lsr_pkg::qent_t head_o
);

  localparam int Depth = lsr_pkg::QUEUE_DEPTH;
  localparam int PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  lsr_pkg::qent_t ent_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] count_q;
  logic            do_push, do_pop;

  assign full_o  = count_q == CntW'(Depth);
  assign empty_o = count_q == '0;
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

FILE: sv/lsr_back.sv
// back end: successor store and output sequencer
// depends on lsr_pkg
`timescale 1ns / 1ps

module lsr_back #(
  parameter int NUM_RULES    = 16,
  parameter int MAX_SUCC_LEN = 64,
  parameter int SYMBOL_BITS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  lsr_pkg::qent_t                 head_i,
  input  logic                           empty_i,
  output logic                           pop_o,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output logic [lsr_pkg::SYM_PORT_W-1:0] out_symbol_o,
  output logic                           from_rule_o,
  output logic                           last_of_run_o
);

  localparam int SymW     = (SYMBOL_BITS < lsr_pkg::SYM_PORT_W) ? SYMBOL_BITS
                                                                : lsr_pkg::SYM_PORT_W;
  localparam int MemDepth = NUM_RULES * MAX_SUCC_LEN;
  localparam int AddrW    = (MemDepth > 1) ? $clog2(MemDepth) : 1;
  localparam int LenW     = $clog2(MAX_SUCC_LEN + 1);

  lsr_pkg::bk_state_e state_q, state_d;

  logic [SymW-1:0]  mem [MemDepth];
  logic [SymW-1:0]  rd_data_q;
  logic [AddrW-1:0] addr_q, addr_d;
  logic [LenW-1:0]  cnt_q, cnt_d;
  logic [LenW-1:0]  len_q, len_d;

  logic             o_valid_q;
  logic [SymW-1:0]  o_sym_q;
  logic             o_rule_q;
  logic             o_last_q;

  logic             out_free;
  logic             run_last;
  logic             wr_en;
  logic             rd_en;
  logic [AddrW-1:0] rd_addr;
  logic             load_out;
  logic [SymW-1:0]  load_sym;
  logic             load_rule;
  logic             load_last;

  assign out_free = !o_valid_q || !out_stall_i;
  assign run_last = (cnt_q + LenW'(1)) == len_q;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      lsr_pkg::BK_IDLE: begin
        if (!empty_i && (head_i.kind == lsr_pkg::K_HIT) && (head_i.len != '0)) begin
          state_d = lsr_pkg::BK_DATA;
        end
      end
      lsr_pkg::BK_DATA: begin
        if (out_free && run_last) begin
          state_d = lsr_pkg::BK_IDLE;
        end
      end
      default: state_d = lsr_pkg::BK_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    pop_o     = 1'b0;
    wr_en     = 1'b0;
    rd_en     = 1'b0;
    rd_addr   = AddrW'(head_i.addr);
    load_out  = 1'b0;
    load_sym  = head_i.sym[SymW-1:0];
    load_rule = 1'b0;
    load_last = 1'b1;
    addr_d    = addr_q;
    cnt_d     = cnt_q;
    len_d     = len_q;
    case (state_q)
      lsr_pkg::BK_IDLE: begin
        if (!empty_i) begin
          case (head_i.kind)
            lsr_pkg::K_WRITE: begin
              pop_o = 1'b1;
              wr_en = 1'b1;
            end
            lsr_pkg::K_PASS: begin
              pop_o    = out_free;
              load_out = out_free;
            end
            lsr_pkg::K_HIT: begin
              pop_o = 1'b1;
              if (head_i.len != '0) begin
                rd_en  = 1'b1;
                addr_d = AddrW'(head_i.addr);
                cnt_d  = '0;
                len_d  = LenW'(head_i.len);
              end
            end
            default: pop_o = 1'b1;
          endcase
        end
      end
      lsr_pkg::BK_DATA: begin
        load_sym  = rd_data_q;
        load_rule = 1'b1;
        load_last = run_last;
        if (out_free) begin
          load_out = 1'b1;
          if (!run_last) begin
            rd_en   = 1'b1;
            rd_addr = addr_q + AddrW'(1);
            addr_d  = addr_q + AddrW'(1);
            cnt_d   = cnt_q + LenW'(1);
          end
        end
      end
      default: begin
        pop_o = 1'b0;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= lsr_pkg::BK_IDLE;
      o_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (load_out) begin
        o_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        o_valid_q <= 1'b0;
      end
    end
  end

  // run counters and output payload
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    cnt_q  <= cnt_d;
    len_q  <= len_d;
    if (load_out) begin
      o_sym_q  <= load_sym;
      o_rule_q <= load_rule;
      o_last_q <= load_last;
    end
  end

  // successor store, registered read
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[AddrW'(head_i.addr)] <= head_i.sym[SymW-1:0];
    end
    if (rd_en) begin
      rd_data_q <= mem[rd_addr];
    end
  end

  assign out_valid_o   = o_valid_q;
  assign out_symbol_o  = lsr_pkg::SYM_PORT_W'(o_sym_q);
  assign from_rule_o   = o_rule_q;
  assign last_of_run_o = o_last_q;

endmodule

FILE: sv/lsystem_symbol_rewriter.sv
// L-system symbol rewriter, D0L rules, one input symbol at a time.
// Input channel (in_valid_i / in_stall_o) takes one beat per cycle while the
// four-entry work queue has room: rewrite symbols, rule headers, successor
// symbols. Headers update the rule table in the accepting cycle and produce
// no output. Output channel (out_valid_o / out_stall_i) gives one symbol per
// beat, with last_of_run_o on the final symbol of each input symbol.
// With an empty queue and a free output, a passed-through symbol passes the
// queue and the output register; the first symbol of a rule's successor passes
// the queue, the registered store read and the output register.
// The pace is set by the back-end sequencer and its single store read port: a
// rewrite that hits a rule holds the back end until its whole successor is read
// out, and headers never reach the back end. Successor symbols stream at one
// per cycle through a registered read while the output is not stalled.
// Reset clears the rule valid marks, the queue and the output register;
// successor symbols and rule contents are undefined until loaded.
// While the receiver stalls the output beat holds, the back end waits, and
// the queue fills before in_stall_o rises.
`timescale 1ns / 1ps
`include "lsystem_symbol_rewriter_defines.svh"

module lsystem_symbol_rewriter #(
  parameter int NUM_RULES    = 16,
  parameter int MAX_SUCC_LEN = 64,
  parameter int SYMBOL_BITS  = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic [lsr_pkg::REQ_W-1:0]      req_type_i,
  input  logic [lsr_pkg::SYM_PORT_W-1:0] symbol_i,
  input  logic [lsr_pkg::IDX_PORT_W-1:0] rule_index_i,
  input  logic [lsr_pkg::POS_PORT_W-1:0] position_i,
  input  logic [lsr_pkg::LEN_PORT_W-1:0] succ_length_i,
  input  logic                           rule_enable_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [lsr_pkg::SYM_PORT_W-1:0] out_symbol_o,
  output logic                           from_rule_o,
  output logic                           last_of_run_o
);

  logic           q_push, q_full, q_pop, q_empty;
  lsr_pkg::qent_t q_entry, q_head;

  // classify and load rules
  lsr_front #(
    .NUM_RULES   (NUM_RULES),
    .MAX_SUCC_LEN(MAX_SUCC_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .symbol_i     (symbol_i),
    .rule_index_i (rule_index_i),
    .position_i   (position_i),
    .succ_length_i(succ_length_i),
    .rule_enable_i(rule_enable_i),
    .q_full_i     (q_full),
    .q_push_o     (q_push),
    .q_entry_o    (q_entry)
  );

  // work queue
  lsr_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (q_push),
    .entry_i(q_entry),
    .full_o (q_full),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .head_o (q_head)
  );

  // successor store and output
  lsr_back #(
    .NUM_RULES   (NUM_RULES),
    .MAX_SUCC_LEN(MAX_SUCC_LEN),
    .SYMBOL_BITS (SYMBOL_BITS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_i       (q_head),
    .empty_i      (q_empty),
    .pop_o        (q_pop),
    .out_stall_i  (out_stall_i),
    .out_valid_o  (out_valid_o),
    .out_symbol_o (out_symbol_o),
    .from_rule_o  (from_rule_o),
    .last_of_run_o(last_of_run_o)
  );

  // checks
  `LSR_ASSERT_NOW(a_pass_is_last, out_valid_o && !from_rule_o, last_of_run_o)
  `LSR_ASSERT_NEXT(a_run_no_bubble, out_valid_o && !out_stall_i && !last_of_run_o, out_valid_o)
  `LSR_ASSERT_NOW(a_pop_not_empty, q_pop, !q_empty)

endmodule

FILE: bench/tb.sv
`timescale 1ns / 1ps
// self-checking bench for lsystem_symbol_rewriter: rule loads, rewrites, pass-through
// depends on lsr_pkg and the rewriter rtl; a scoreboard class predicts every output beat

module tb;

  localparam int NUM_RULES    = 16;
  localparam int MAX_SUCC_LEN = 64;
  localparam int QUIET_LIMIT  = 1000;
  localparam int TAIL_CYCLES  = 16;
  localparam int PHASE_ITEMS  = 28;
  localparam logic [lsr_pkg::REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [lsr_pkg::SYM_PORT_W-1:0] sym;
    logic                           from_rule;
    logic                           last;
  } out_beat_t;

  // rule table copy plus the queue of symbols still owed by the block
  class rewrite_scoreboard;
    bit                             rule_on   [NUM_RULES];
    logic [lsr_pkg::SYM_PORT_W-1:0] rule_pred [NUM_RULES];
    int unsigned                    rule_len  [NUM_RULES];
    logic [lsr_pkg::SYM_PORT_W-1:0] succ_mem  [NUM_RULES][MAX_SUCC_LEN];
    out_beat_t                      pending_symbols [$];
    int unsigned                    errors;

    function new();
      foreach (rule_on[r]) rule_on[r] = 1'b0;
      errors = 0;
    endfunction

    function int unsigned pending();
      return pending_symbols.size();
    endfunction

    // apply a load, or predict the symbols a rewrite produces
    function void note_request(logic [lsr_pkg::REQ_W-1:0] req,
                               logic [lsr_pkg::SYM_PORT_W-1:0] sym,
                               logic [lsr_pkg::IDX_PORT_W-1:0] idx,
                               logic [lsr_pkg::POS_PORT_W-1:0] pos,
                               logic [lsr_pkg::LEN_PORT_W-1:0] len, logic en);
      int hit;
      hit = -1;
      case (req)
        lsr_pkg::REQ_HEADER: begin
          // stored even when the rule is disabled; length saturates
          rule_pred[idx] = sym;
          rule_len[idx]  = (len > MAX_SUCC_LEN) ? MAX_SUCC_LEN : len;
          rule_on[idx]   = en;
        end
        lsr_pkg::REQ_SUCC: succ_mem[idx][pos] = sym;
        lsr_pkg::REQ_REWRITE: begin
          // lowest valid matching slot wins
          for (int r = NUM_RULES - 1; r >= 0; r--)
            if (rule_on[r] && rule_pred[r] == sym) hit = r;
          if (hit < 0) begin
            pending_symbols.push_back('{sym, 1'b0, 1'b1});
          end else begin
            for (int i = 0; i < rule_len[hit]; i++)
              pending_symbols.push_back('{succ_mem[hit][i], 1'b1, (i + 1 == rule_len[hit])});
          end
        end
        default: ;  // unused request code changes nothing
      endcase
    endfunction

    function void check_symbol(logic [lsr_pkg::SYM_PORT_W-1:0] sym, logic from_rule,
                               logic last);
      out_beat_t want;
      if (pending_symbols.size() == 0) begin
        $error("output beat with nothing expected: out_symbol %0d", sym);
        errors++;
        return;
      end
      want = pending_symbols.pop_front();
      if (sym !== want.sym) begin
        $error("out_symbol: expected %0d, got %0d", want.sym, sym);
        errors++;
      end
      if (from_rule !== want.from_rule) begin
        $error("from_rule: expected %0d, got %0d", want.from_rule, from_rule);
        errors++;
      end
      if (last !== want.last) begin
        $error("last_of_run: expected %0d, got %0d", want.last, last);
        errors++;
      end
    endfunction
  endclass

  logic                           clk_i         = 1'b0;
  logic                           rst_ni        = 1'b0;
  logic                           in_valid_i    = 1'b0;
  logic                           in_stall_o;
  logic [lsr_pkg::REQ_W-1:0]      req_type_i    = '0;
  logic [lsr_pkg::SYM_PORT_W-1:0] symbol_i      = '0;
  logic [lsr_pkg::IDX_PORT_W-1:0] rule_index_i  = '0;
  logic [lsr_pkg::POS_PORT_W-1:0] position_i    = '0;
  logic [lsr_pkg::LEN_PORT_W-1:0] succ_length_i = '0;
  logic                           rule_enable_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i   = 1'b0;
  logic [lsr_pkg::SYM_PORT_W-1:0] out_symbol_o;
  logic                           from_rule_o;
  logic                           last_of_run_o;

  rewrite_scoreboard sb;
  int unsigned sender_idle_pct = 0;
  int unsigned recv_stall_pct  = 0;
  int unsigned sent_items      = 0;
  // successor positions loaded so far, per slot
  logic [MAX_SUCC_LEN-1:0] loaded_pos [NUM_RULES] = '{default: '0};

  lsystem_symbol_rewriter #(
    .NUM_RULES   (NUM_RULES),
    .MAX_SUCC_LEN(MAX_SUCC_LEN),
    .SYMBOL_BITS (8)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .req_type_i   (req_type_i),
    .symbol_i     (symbol_i),
    .rule_index_i (rule_index_i),
    .position_i   (position_i),
    .succ_length_i(succ_length_i),
    .rule_enable_i(rule_enable_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_symbol_o (out_symbol_o),
    .from_rule_o  (from_rule_o),
    .last_of_run_o(last_of_run_o)
  );

  // 12 ns clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver stalls at random
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // accepted beats on both channels go to the scoreboard
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        sb.note_request(req_type_i, symbol_i, rule_index_i, position_i, succ_length_i,
                        rule_enable_i);
      if (out_valid_o && !out_stall_i)
        sb.check_symbol(out_symbol_o, from_rule_o, last_of_run_o);
    end
  end

  // end the run when no beat moves for too long
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    @(posedge rst_ni);
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) quiet = 0;
      else quiet++;
    end
    $display("FAILURE");
    $finish;
  end

  // one input beat, after a random gap, held until accepted
  task automatic send_beat(input logic [lsr_pkg::REQ_W-1:0] req,
                           input logic [lsr_pkg::SYM_PORT_W-1:0] sym,
                           input logic [lsr_pkg::IDX_PORT_W-1:0] idx,
                           input logic [lsr_pkg::POS_PORT_W-1:0] pos,
                           input logic [lsr_pkg::LEN_PORT_W-1:0] len, input logic en);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= req;
    symbol_i      <= sym;
    rule_index_i  <= idx;
    position_i    <= pos;
    succ_length_i <= len;
    rule_enable_i <= en;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    if (req != REQ_UNUSED) sent_items++;
  endtask

  task automatic send_rewrite(input logic [lsr_pkg::SYM_PORT_W-1:0] sym);
    send_beat(lsr_pkg::REQ_REWRITE, sym, lsr_pkg::IDX_PORT_W'($urandom),
              lsr_pkg::POS_PORT_W'($urandom), lsr_pkg::LEN_PORT_W'($urandom),
              1'($urandom));
  endtask

  task automatic send_header(input logic [lsr_pkg::IDX_PORT_W-1:0] slot,
                             input logic [lsr_pkg::SYM_PORT_W-1:0] pred,
                             input logic [lsr_pkg::LEN_PORT_W-1:0] len, input logic en);
    send_beat(lsr_pkg::REQ_HEADER, pred, slot, lsr_pkg::POS_PORT_W'($urandom), len, en);
  endtask

  task automatic send_succ(input logic [lsr_pkg::IDX_PORT_W-1:0] slot,
                           input logic [lsr_pkg::POS_PORT_W-1:0] pos,
                           input logic [lsr_pkg::SYM_PORT_W-1:0] sym);
    loaded_pos[slot][pos] = 1'b1;
    send_beat(lsr_pkg::REQ_SUCC, sym, slot, pos, lsr_pkg::LEN_PORT_W'($urandom),
              1'($urandom));
  endtask

  // well-formed rule: every successor symbol first, then the enabling header
  task automatic define_rule(input logic [lsr_pkg::IDX_PORT_W-1:0] slot,
                             input int unsigned n_succ,
                             input logic [lsr_pkg::LEN_PORT_W-1:0] hdr_len,
                             input logic [lsr_pkg::SYM_PORT_W-1:0] pred);
    for (int p = 0; p < n_succ; p++)
      send_succ(slot, lsr_pkg::POS_PORT_W'(p), lsr_pkg::SYM_PORT_W'($urandom));
    send_header(slot, pred, hdr_len, 1'b1);
  endtask

  // small alphabet most of the time so rules hit often
  function automatic logic [lsr_pkg::SYM_PORT_W-1:0] pick_symbol();
    if ($urandom_range(9) < 6) return {5'b01000, 3'($urandom)};
    return lsr_pkg::SYM_PORT_W'($urandom);
  endfunction

  initial begin : stimulus
    int unsigned                    roll;
    int unsigned                    n_succ;
    int unsigned                    target;
    int unsigned                    sat_len;
    logic [lsr_pkg::IDX_PORT_W-1:0] slot;
    logic [lsr_pkg::LEN_PORT_W-1:0] hdr_len;
    logic                           en;
    logic [MAX_SUCC_LEN-1:0]        need;
    sb = new();
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: pass-through extremes, ignored code, priority, deletion, invalidation
    send_rewrite(8'h00);
    send_rewrite(8'hFF);
    send_beat(REQ_UNUSED, 8'hFF, 4'hF, 6'h3F, 7'h7F, 1'b1);
    send_succ(4'd15, 6'd63, 8'hFF);
    define_rule(4'd15, 1, 7'd1, 8'hA5);
    send_rewrite(8'hA5);
    define_rule(4'd0, 3, 7'd3, 8'hA5);
    send_rewrite(8'hA5);
    send_header(4'd0, 8'h5A, 7'd0, 1'b1);
    send_rewrite(8'h5A);
    send_rewrite(8'hA5);
    send_header(4'd15, 8'hA5, 7'h7F, 1'b0);
    send_rewrite(8'hA5);
    send_header(4'd0, 8'h00, 7'd0, 1'b0);
    send_rewrite(8'h5A);

    // one full-length rule with a saturating header length
    define_rule(lsr_pkg::IDX_PORT_W'($urandom), MAX_SUCC_LEN,
                lsr_pkg::LEN_PORT_W'($urandom_range(127, 64)), pick_symbol());

    // random traffic under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin sender_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin sender_idle_pct = 71; recv_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  recv_stall_pct = 71; end
        default: begin sender_idle_pct = 17; recv_stall_pct = 17; end
      endcase
      target = sent_items + PHASE_ITEMS;
      while (sent_items < target) begin
        roll = $urandom_range(99);
        slot = lsr_pkg::IDX_PORT_W'($urandom);
        if (roll < 50) begin
          send_rewrite(pick_symbol());
        end else if (roll < 70) begin
          // mostly short successors, now and then the longest
          if ($urandom_range(99) < 8) begin
            n_succ  = MAX_SUCC_LEN;
            hdr_len = lsr_pkg::LEN_PORT_W'($urandom_range(127, 64));
          end else begin
            n_succ  = $urandom_range(6);
            hdr_len = lsr_pkg::LEN_PORT_W'(n_succ);
          end
          define_rule(slot, n_succ, hdr_len, pick_symbol());
        end else if (roll < 82) begin
          send_succ(slot, lsr_pkg::POS_PORT_W'($urandom), lsr_pkg::SYM_PORT_W'($urandom));
        end else if (roll < 95) begin
          // stray header; enabled only when its successor is fully loaded
          hdr_len = ($urandom_range(1) == 0) ? lsr_pkg::LEN_PORT_W'($urandom_range(7))
                                             : lsr_pkg::LEN_PORT_W'($urandom);
          en      = 1'($urandom);
          sat_len = (hdr_len > MAX_SUCC_LEN) ? MAX_SUCC_LEN : hdr_len;
          need    = (sat_len == MAX_SUCC_LEN) ? '1 : ((MAX_SUCC_LEN'(1) << sat_len) - 1'b1);
          if (en && ((loaded_pos[slot] & need) != need)) en = 1'b0;
          send_header(slot, pick_symbol(), hdr_len, en);
        end else begin
          send_beat(REQ_UNUSED, lsr_pkg::SYM_PORT_W'($urandom), slot,
                    lsr_pkg::POS_PORT_W'($urandom), lsr_pkg::LEN_PORT_W'($urandom),
                    1'($urandom));
        end
      end
    end

    // drain, then watch a while for stray beats
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.pending() != 0) @(posedge clk_i);
    recv_stall_pct = 0;
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending() == 0) $display("SUCCESS");
    else $display("FAILURE");
    $finish;
  end

endmodule
